>>> design/dq_pkg.sv
// Shared types, constants and index helpers for the double-ended queue.
// Used by every module of the block; depends on nothing else.

package dq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Stream widths: fields packed from bit 0, padded to whole bytes.
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = ((REQ_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((STATUS_W + VAL_W + 7) / 8) * 8;

    // Request codes as they arrive on the input stream.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Command queue between the front end and the execution unit.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_LIST
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] value;
    } cmd_t;

    // Ring index arithmetic; works for any depth, not only powers of two.
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] res;
        if (a == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = a - 1'b1;
        end
        return res;
    endfunction

endpackage

>>> design/double_ended_queue.sv
// Double-ended queue of signed 32-bit values in a ring store.
// A request beat is held in the command queue; the execution unit then takes it
// and registers its first result beat in the output register.
// Throughput: one push or pop per cycle unless m_tready holds the output; a list
// request reads one entry per beat through the single store read port.
// Reset (aresetn low) empties the queue; stored values are not cleared.

module double_ended_queue
    import dq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // req_type[2:0], push_value[34:3]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // status[1:0], out_value[33:2]
    output logic                 m_tlast    // last_of_run
);

    logic fe_valid, fe_ready;
    cmd_t fe_cmd;
    logic be_valid, be_ready;
    cmd_t be_cmd;

    dq_front u_front (
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd       (fe_cmd)
    );

    dq_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_cmd   (fe_cmd),
        .rd_valid (be_valid),
        .rd_ready (be_ready),
        .rd_cmd   (be_cmd)
    );

    dq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (be_valid),
        .cmd_ready (be_ready),
        .cmd       (be_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> design/dq_front.sv
// Front end of the double-ended queue: takes request beats and decodes them.
// Unknown request codes are swallowed; the rest go to the command queue.
// Depends on dq_pkg.

module dq_front
    import dq_pkg::*;
(
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    logic [REQ_W-1:0] req_type;
    logic             known;
    op_t              op;

    assign req_type = s_tdata[REQ_W-1:0];

    always_comb begin
        known = 1'b1;
        op    = OP_LIST;
        unique case (req_type)
            REQ_PUSH_FRONT: op = OP_PUSH_FRONT;
            REQ_PUSH_BACK:  op = OP_PUSH_BACK;
            REQ_POP_FRONT:  op = OP_POP_FRONT;
            REQ_POP_BACK:   op = OP_POP_BACK;
            REQ_LIST:       op = OP_LIST;
            default:        known = 1'b0;
        endcase
    end

    // A beat is taken whenever the queue has room, even if it is dropped.
    assign s_tready  = cmd_ready && aresetn;
    assign cmd_valid = s_tvalid && known && aresetn;
    assign cmd.op    = op;
    assign cmd.value = s_tdata[REQ_W +: VAL_W];

endmodule

>>> design/dq_cmd_fifo.sv
// Short command queue that decouples request decode from execution.
// Register based, CMDQ_DEPTH entries deep; depends on dq_pkg.

module dq_cmd_fifo
    import dq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    cmd_t                  slots_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] fill_reg, fill_next;
    logic                  do_wr, do_rd;

    assign wr_ready = (fill_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slots_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> design/dq_back.sv
// Execution unit of the double-ended queue: ring store, front index, count
// and the output register. Takes commands from the queue; depends on dq_pkg.

module dq_back
    import dq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     list_off_reg, list_off_next;
    logic                 valid_reg, valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [VAL_W-1:0]     value_reg, value_next;
    logic                 last_reg, last_next;

    logic [VAL_W-1:0]     store [DEPTH];
    logic                 out_free;
    logic                 take;
    logic                 wr_en;
    logic                 rd_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     back_off;
    logic [CNT_W-1:0]     count_m1;

    assign out_free  = !valid_reg || m_tready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;
    assign count_m1  = count_reg - 1'b1;
    assign back_off  = count_m1[IDX_W-1:0];

    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        list_off_next = list_off_reg;
        valid_next    = valid_reg && !m_tready;
        status_next   = status_reg;
        value_next    = value_reg;
        last_next     = last_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        wr_addr       = front_reg;
        rd_addr       = front_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    value_next  = '0;
                    last_next   = 1'b1;
                    unique case (cmd.op) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (count_reg == DEPTH_C) begin
                                status_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (cmd.op == OP_PUSH_FRONT) begin
                                    wr_addr    = idx_dec(front_reg);
                                    front_next = idx_dec(front_reg);
                                end else begin
                                    wr_addr = idx_add(front_reg, count_reg[IDX_W-1:0]);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next = count_m1;
                                rd_en      = 1'b1;
                                if (cmd.op == OP_POP_FRONT) begin
                                    rd_addr    = front_reg;
                                    front_next = idx_add(front_reg, IDX_W'(1));
                                end else begin
                                    rd_addr = idx_add(front_reg, back_off);
                                end
                            end
                        end
                        OP_LIST: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rd_addr = front_reg;
                                rd_en   = 1'b1;
                                if (count_reg != CNT_W'(1)) begin
                                    // More entries follow: walk the rest one per beat.
                                    last_next     = 1'b0;
                                    list_off_next = IDX_W'(1);
                                    state_next    = S_LIST;
                                end
                            end
                        end
                        default: begin
                            valid_next = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (out_free) begin
                    rd_addr       = idx_add(front_reg, list_off_reg);
                    rd_en         = 1'b1;
                    valid_next    = 1'b1;
                    status_next   = ST_OK;
                    last_next     = (list_off_reg == back_off);
                    list_off_next = list_off_reg + 1'b1;
                    if (list_off_reg == back_off) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            list_off_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            list_off_reg <= list_off_next;
            valid_reg    <= valid_next;
        end
        status_reg <= status_next;
        // The store is read straight into the output register.
        value_reg  <= rd_en ? store[rd_addr] : value_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= cmd.value;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = M_TDATA_W'({value_reg, status_reg});

endmodule
